/* hdl/orl_pkg.sv */
package orl_pkg;

  // default store depth
  localparam int unsigned DEPTH_DEF = 16;

  // field widths
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned AGE_W    = 8;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned HEIGHT_W = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_INS_FRONT  = 3'd0,
    FN_INS_BACK   = 3'd1,
    FN_INS_SORTED = 3'd2,
    FN_FIND       = 3'd3,
    FN_REMOVE     = 3'd4
  } func_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  // one stored record
  typedef struct packed {
    logic [AGE_W-1:0]    age;
    logic [ID_W-1:0]     id;
    logic [HEIGHT_W-1:0] height;
  } rec_t;

  // broadcast to all cells when an item is taken in
  typedef struct packed {
    logic              en;
    logic [FUNC_W-1:0] func;
    rec_t              rec;
  } cap_t;

  // broadcast to all cells in the update cycle
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

/* hdl/orl_if.sv */
interface orl_in_if;
  logic                            valid;
  logic                            ready;
  logic [orl_pkg::FUNC_W-1:0]      func;
  logic [orl_pkg::AGE_W-1:0]       age;
  logic [orl_pkg::ID_W-1:0]        rec_id;
  logic [orl_pkg::HEIGHT_W-1:0]    height_bits;

  modport source (output valid, func, age, rec_id, height_bits, input ready);
  modport sink (input valid, func, age, rec_id, height_bits, output ready);
endinterface

interface orl_out_if;
  logic                            valid;
  logic                            ready;
  logic [orl_pkg::STATUS_W-1:0]    status;
  logic [orl_pkg::AGE_W-1:0]       out_age;
  logic [orl_pkg::ID_W-1:0]        out_id;
  logic [orl_pkg::HEIGHT_W-1:0]    out_height_bits;
  logic [orl_pkg::COUNT_W-1:0]     entry_count;

  modport source (output valid, status, out_age, out_id, out_height_bits, entry_count,
                  input ready);
  modport sink (input valid, status, out_age, out_id, out_height_bits, entry_count,
                output ready);
endinterface

/* hdl/ordered_record_list.sv */
// channel | dir | payload                                                    | handshake
// req_i   | in  | func, age, rec_id, height_bits                             | valid/ready
// rsp_o   | out | status, out_age, out_id, out_height_bits, entry_count      | valid/ready
//
// each item passes through a take-in cycle, where every cell compares its record against
// the item, and an update cycle, where the first-mark chain through the cells settles and
// the cells shift; one item is in work at a time
// the update waits while the result register is full and not being taken
// reset empties the store; no clearing pass is needed
module ordered_record_list #(
  parameter int unsigned DEPTH = orl_pkg::DEPTH_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  orl_in_if.sink      req_i,
  orl_out_if.source   rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  orl_pkg::state_e     state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [orl_pkg::FUNC_W-1:0] func_q;
  orl_pkg::rec_t       new_rec_q;

  logic                accept;
  logic                slot_free;
  logic                apply;
  logic                full;
  logic                is_ins;
  logic                is_lookup;
  logic                hit_any;
  orl_pkg::cap_t       cap;
  orl_pkg::cell_ctl_t  ctl;

  orl_pkg::rec_t       rec   [DEPTH];
  logic                seen  [DEPTH+1];
  orl_pkg::rec_t       hit   [DEPTH+1];

  logic                        rsp_valid_q;
  logic [orl_pkg::STATUS_W-1:0] status_q, status_d;
  orl_pkg::rec_t               out_rec_q, out_rec_d;

  // handshake and sequencer strobes
  assign accept    = req_i.valid && req_i.ready;
  assign slot_free = !rsp_valid_q || rsp_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      orl_pkg::S_IDLE: if (accept) state_d = orl_pkg::S_RUN;
      orl_pkg::S_RUN:  if (slot_free) state_d = orl_pkg::S_IDLE;
      default:         state_d = orl_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req_i.ready = 1'b0;
    apply       = 1'b0;
    unique case (state_q)
      orl_pkg::S_IDLE: req_i.ready = 1'b1;
      orl_pkg::S_RUN:  apply = slot_free;
      default: begin
        req_i.ready = 1'b0;
        apply       = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= orl_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // item broadcast to the cells
  assign cap.en         = accept;
  assign cap.func       = req_i.func;
  assign cap.rec.age    = req_i.age;
  assign cap.rec.id     = req_i.rec_id;
  assign cap.rec.height = req_i.height_bits;

  // hold the operation for the update cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q    <= req_i.func;
      new_rec_q <= cap.rec;
    end
  end

  // operation decode
  assign full      = (count_q == CntW'(DEPTH));
  assign is_ins    = (func_q == orl_pkg::FN_INS_FRONT) || (func_q == orl_pkg::FN_INS_BACK) ||
                     (func_q == orl_pkg::FN_INS_SORTED);
  assign is_lookup = (func_q == orl_pkg::FN_FIND) || (func_q == orl_pkg::FN_REMOVE);
  assign hit_any   = seen[DEPTH];
  assign ctl.ins   = apply && is_ins && !full;
  assign ctl.rem   = apply && (func_q == orl_pkg::FN_REMOVE);

  // chain of cells, head at index 0
  assign seen[0] = 1'b0;
  assign hit[0]  = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    orl_pkg::rec_t left_rec;
    orl_pkg::rec_t right_rec;

    if (i == 0) begin : g_head
      assign left_rec = rec[i];
    end else begin : g_body
      assign left_rec = rec[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_rec = rec[i];
    end else begin : g_inner
      assign right_rec = rec[i+1];
    end

    orl_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .head_i      (i == 0),
      .occ_i       (CntW'(i) < count_q),
      .tail_i      (CntW'(i) == count_q),
      .cap_i       (cap),
      .ctl_i       (ctl),
      .new_rec_i   (new_rec_q),
      .left_rec_i  (left_rec),
      .right_rec_i (right_rec),
      .rec_o       (rec[i]),
      .seen_i      (seen[i]),
      .seen_o      (seen[i+1]),
      .hit_i       (hit[i]),
      .hit_o       (hit[i+1])
    );
  end

  // result and count update
  always_comb begin
    count_d   = count_q;
    status_d  = orl_pkg::ST_OK;
    out_rec_d = '0;
    if (is_ins) begin
      if (full) begin
        status_d = orl_pkg::ST_FULL;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else if (is_lookup) begin
      if (!hit_any) begin
        status_d = orl_pkg::ST_MISS;
      end else begin
        out_rec_d = hit[DEPTH];
        if (func_q == orl_pkg::FN_REMOVE) begin
          count_d = count_q - CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (apply) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (apply) begin
      status_q  <= status_d;
      out_rec_q <= out_rec_d;
    end
  end

  logic [CntW-1:0] count_rsp_q;

  always_ff @(posedge clk_i) begin
    if (apply) begin
      count_rsp_q <= count_d;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = status_q;
  assign rsp_o.out_age         = out_rec_q.age;
  assign rsp_o.out_id          = out_rec_q.id;
  assign rsp_o.out_height_bits = out_rec_q.height;
  assign rsp_o.entry_count     = orl_pkg::COUNT_W'(count_rsp_q);

endmodule

/* hdl/orl_cell.sv */
module orl_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_i,
  input  logic                occ_i,
  input  logic                tail_i,
  input  orl_pkg::cap_t       cap_i,
  input  orl_pkg::cell_ctl_t  ctl_i,
  input  orl_pkg::rec_t       new_rec_i,
  input  orl_pkg::rec_t       left_rec_i,
  input  orl_pkg::rec_t       right_rec_i,
  output orl_pkg::rec_t       rec_o,
  input  logic                seen_i,
  output logic                seen_o,
  input  orl_pkg::rec_t       hit_i,
  output orl_pkg::rec_t       hit_o
);

  orl_pkg::rec_t rec_q, rec_d;
  logic          mark_q, mark_d;
  logic          first;

  // mark this cell when the new item picks it as its position, or matches its id on a lookup
  always_comb begin
    mark_d = mark_q;
    if (cap_i.en) begin
      unique case (cap_i.func)
        orl_pkg::FN_INS_FRONT:  mark_d = head_i;
        orl_pkg::FN_INS_BACK:   mark_d = 1'b0;
        orl_pkg::FN_INS_SORTED: mark_d = occ_i && (head_i ? (cap_i.rec.age < rec_q.age)
                                                           : (cap_i.rec.age <= rec_q.age));
        orl_pkg::FN_FIND,
        orl_pkg::FN_REMOVE:     mark_d = occ_i && (cap_i.rec.id == rec_q.id);
        default:                mark_d = 1'b0;
      endcase
    end
  end

  // first mark from the head wins
  assign first  = mark_q && !seen_i;
  assign seen_o = seen_i || mark_q;
  assign hit_o  = first ? rec_q : hit_i;
  assign rec_o  = rec_q;

  // shift toward the tail on insert, toward the head on remove
  always_comb begin
    rec_d = rec_q;
    priority if (ctl_i.ins) begin
      priority if (first || (tail_i && !seen_i)) begin
        rec_d = new_rec_i;
      end else if (seen_i) begin
        rec_d = left_rec_i;
      end else begin
        rec_d = rec_q;
      end
    end else if (ctl_i.rem && seen_o) begin
      rec_d = right_rec_i;
    end else begin
      rec_d = rec_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= 1'b0;
    end else begin
      mark_q <= mark_d;
    end
  end

endmodule

/* tb/tb_ordered_record_list.sv */
`timescale 1ns / 100ps

module tb_ordered_record_list;
  import orl_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 20;

  // function codes the block must treat as no-ops
  localparam logic [FUNC_W-1:0] FN_UNUSED_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FN_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [AGE_W-1:0]    age;
    logic [ID_W-1:0]     id;
    logic [HEIGHT_W-1:0] height;
    logic [COUNT_W-1:0]  count;
  } list_result_t;

  logic clk;
  logic rst_n;

  orl_in_if  req_if ();
  orl_out_if rsp_if ();

  ordered_record_list #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // shadow copy of the record store
  logic [AGE_W-1:0]    shadow_age    [DEPTH];
  logic [ID_W-1:0]     shadow_id     [DEPTH];
  logic [HEIGHT_W-1:0] shadow_height [DEPTH];
  int unsigned         shadow_count;

  list_result_t pending_results[$];

  int unsigned error_count;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned hits_seen;
  int unsigned misses_seen;
  int unsigned drops_seen;
  int unsigned cycle_count;
  bit          stalls_on;

  // clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // runs one operation on the shadow store and returns the result it must give
  function automatic list_result_t apply_list_op(logic [FUNC_W-1:0] func,
                                                 logic [AGE_W-1:0] age,
                                                 logic [ID_W-1:0] id,
                                                 logic [HEIGHT_W-1:0] height);
    list_result_t res;
    int unsigned  pos;
    int unsigned  i;
    bit           is_insert;
    res = '0;
    res.status = ST_OK;
    is_insert = (func == FN_INS_FRONT) || (func == FN_INS_BACK) || (func == FN_INS_SORTED);
    if (is_insert) begin
      if (shadow_count >= DEPTH) begin
        res.status = ST_FULL;
        drops_seen++;
      end else begin
        // pick the slot
        if (func == FN_INS_FRONT) begin
          pos = 0;
        end else if (func == FN_INS_BACK) begin
          pos = shadow_count;
        end else if (shadow_count == 0 || age < shadow_age[0]) begin
          pos = 0;
        end else begin
          pos = 1;
          while (pos < shadow_count && age > shadow_age[pos]) pos++;
        end
        // open the gap and fill it
        for (i = shadow_count; i > pos; i--) begin
          shadow_age[i]    = shadow_age[i-1];
          shadow_id[i]     = shadow_id[i-1];
          shadow_height[i] = shadow_height[i-1];
        end
        shadow_age[pos]    = age;
        shadow_id[pos]     = id;
        shadow_height[pos] = height;
        shadow_count++;
      end
    end else if (func == FN_FIND || func == FN_REMOVE) begin
      pos = 0;
      while (pos < shadow_count && shadow_id[pos] != id) pos++;
      if (pos >= shadow_count) begin
        res.status = ST_MISS;
        misses_seen++;
      end else begin
        hits_seen++;
        res.age    = shadow_age[pos];
        res.id     = shadow_id[pos];
        res.height = shadow_height[pos];
        if (func == FN_REMOVE) begin
          for (i = pos; i + 1 < shadow_count; i++) begin
            shadow_age[i]    = shadow_age[i+1];
            shadow_id[i]     = shadow_id[i+1];
            shadow_height[i] = shadow_height[i+1];
          end
          shadow_count--;
        end
      end
    end
    res.count = shadow_count[COUNT_W-1:0];
    return res;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!stalls_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ages: extremes and a narrow band for ties, otherwise anything
  function automatic logic [AGE_W-1:0] pick_age();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return AGE_W'($urandom_range(100, 107));
      default: return AGE_W'($urandom);
    endcase
  endfunction

  // ids: mostly ones held now, so lookups hit, else small or wide values
  function automatic logic [ID_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (shadow_count > 0 && r < 7) return shadow_id[$urandom_range(0, shadow_count - 1)];
    if (r < 8) return ID_W'($urandom_range(0, 11));
    return ID_W'($urandom);
  endfunction

  function automatic logic [FUNC_W-1:0] pick_insert();
    return FUNC_W'($urandom_range(FN_INS_SORTED, FN_INS_FRONT));
  endfunction

  task automatic report_error(string msg);
    error_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // send one item, called at a falling edge, returns at a falling edge
  task automatic send_op(logic [FUNC_W-1:0] func, logic [AGE_W-1:0] age,
                         logic [ID_W-1:0] id, logic [HEIGHT_W-1:0] height);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.func        <= func;
    req_if.age         <= age;
    req_if.rec_id      <= id;
    req_if.height_bits <= height;
    do @(posedge clk); while (!req_if.ready);
    pending_results.push_back(apply_list_op(func, age, id, height));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_op(int unsigned insert_weight);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < insert_weight)
      send_op(pick_insert(), pick_age(), pick_key(), $urandom);
    else if (r < insert_weight + (95 - insert_weight) / 2)
      send_op(FN_FIND, pick_age(), pick_key(), $urandom);
    else if (r < 95)
      send_op(FN_REMOVE, pick_age(), pick_key(), $urandom);
    else
      send_op(FUNC_W'($urandom_range(FN_UNUSED_LAST, FN_UNUSED_FIRST)), pick_age(),
              pick_key(), $urandom);
  endtask

  // empty store, sorted insert cases, field extremes, duplicates, unused codes
  task automatic test_directed();
    send_op(FN_FIND, 8'd0, 16'h0000, 32'h0);
    send_op(FN_REMOVE, 8'd0, 16'hFFFF, 32'h0);
    send_op(FN_INS_SORTED, 8'd100, 16'd1, 32'h0000_0000);
    // smaller than the head goes in front
    send_op(FN_INS_SORTED, 8'd50, 16'd2, 32'h1234_5678);
    // equal to the head goes after it
    send_op(FN_INS_SORTED, 8'd50, 16'd3, 32'h8765_4321);
    // larger than all goes to the tail
    send_op(FN_INS_SORTED, 8'd255, 16'd4, 32'hDEAD_BEEF);
    // equal to a later entry goes before it
    send_op(FN_INS_SORTED, 8'd100, 16'd5, 32'hCAFE_F00D);
    send_op(FN_INS_FRONT, 8'd0, 16'hFFFF, 32'hFFFF_FFFF);
    send_op(FN_INS_BACK, 8'd255, 16'h0000, 32'hFFFF_FFFF);
    send_op(FN_INS_BACK, 8'd7, 16'd1, 32'hA5A5_A5A5);
    send_op(FN_FIND, 8'd0, 16'd1, 32'h0);
    send_op(FN_FIND, 8'd0, 16'd7, 32'h0);
    send_op(FN_UNUSED_FIRST, 8'd255, 16'hFFFF, 32'hFFFF_FFFF);
    send_op(FUNC_W'(FN_UNUSED_FIRST + 1), 8'd1, 16'd1, 32'h1);
    send_op(FN_UNUSED_LAST, 8'd0, 16'd2, 32'h0);
    // duplicate id: the copy nearest the head goes first
    send_op(FN_REMOVE, 8'd0, 16'd1, 32'h0);
    send_op(FN_FIND, 8'd0, 16'd1, 32'h0);
    send_op(FN_REMOVE, 8'd0, 16'hFFFF, 32'h0);
    send_op(FN_REMOVE, 8'd0, 16'h0000, 32'h0);
    send_op(FN_REMOVE, 8'd0, 16'hABCD, 32'h0);
    send_op(FN_FIND, 8'd0, 16'd5, 32'h0);
  endtask

  // fill to full, push dropped inserts, then drain to empty
  task automatic test_fill_drain(int unsigned rounds);
    repeat (rounds) begin
      while (shadow_count < DEPTH) begin
        if ($urandom_range(0, 4) == 0) send_op(FN_FIND, pick_age(), pick_key(), $urandom);
        else send_op(pick_insert(), pick_age(), pick_key(), $urandom);
      end
      repeat ($urandom_range(1, 3)) send_op(pick_insert(), pick_age(), pick_key(), $urandom);
      while (shadow_count > 0) begin
        if ($urandom_range(0, 5) == 0) send_op(FN_FIND, pick_age(), pick_key(), $urandom);
        else send_op(FN_REMOVE, pick_age(), pick_key(), $urandom);
      end
      send_op(FN_REMOVE, pick_age(), pick_key(), $urandom);
    end
  endtask

  // random mix with an insert bias that wanders
  task automatic test_random_mix(int unsigned n_ops);
    int unsigned insert_weight;
    insert_weight = 40;
    for (int unsigned n = 0; n < n_ops; n++) begin
      if (n % 50 == 0) insert_weight = $urandom_range(20, 60);
      send_random_op(insert_weight);
    end
  endtask

  // back-to-back items with the result side always ready
  task automatic test_full_rate(int unsigned n_ops);
    stalls_on = 1'b0;
    test_random_mix(n_ops);
    stalls_on = 1'b1;
  endtask

  // result side ready pattern
  initial begin
    int unsigned gap;
    rsp_if.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  // compare each result with the oldest prediction
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got.status = rsp_if.status;
      got.age    = rsp_if.out_age;
      got.id     = rsp_if.out_id;
      got.height = rsp_if.out_height_bits;
      got.count  = rsp_if.entry_count;
      results_seen++;
      if (pending_results.size() == 0) begin
        report_error($sformatf("result with none pending: %p", got));
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          report_error($sformatf("status %0d, wanted %0d", got.status, want.status));
        if (got.age !== want.age)
          report_error($sformatf("out_age %0d, wanted %0d", got.age, want.age));
        if (got.id !== want.id)
          report_error($sformatf("out_id %h, wanted %h", got.id, want.id));
        if (got.height !== want.height)
          report_error($sformatf("out_height_bits %h, wanted %h", got.height, want.height));
        if (got.count !== want.count)
          report_error($sformatf("entry_count %0d, wanted %0d", got.count, want.count));
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycle_count,
             pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // main sequence
  initial begin
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.func        = '0;
    req_if.age         = '0;
    req_if.rec_id      = '0;
    req_if.height_bits = '0;
    stalls_on          = 1'b1;
    shadow_count       = 0;
    error_count        = 0;
    items_sent         = 0;
    results_seen       = 0;
    hits_seen          = 0;
    misses_seen        = 0;
    drops_seen         = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_fill_drain(8);
    test_random_mix(1100);
    test_full_rate(300);

    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d items, checked %0d results in %0d cycles", items_sent, results_seen,
             cycle_count);
    $display("lookups: %0d hits, %0d misses; %0d inserts dropped on a full store",
             hits_seen, misses_seen, drops_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/orl_pkg.sv
hdl/orl_if.sv
hdl/orl_cell.sv
hdl/ordered_record_list.sv
tb/tb_ordered_record_list.sv
